// ----- rtl/core/jadsc_pkg.sv -----
// Shared types and constants for the joystick axis dead-zone scaler.
package jadsc_pkg;

    localparam int DATA_W = 12;
    localparam int POS_W = 8;
    localparam int PROD_W = 19;
    localparam int CFG_IDX_W = 2;

    localparam logic [DATA_W-1:0] FULL_SCALE = 12'd4095;

    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_LOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_HIGH = 2'd1;

    localparam logic [DATA_W-1:0] DEAD_LOW_RST = 12'd2124;
    localparam logic [DATA_W-1:0] DEAD_HIGH_RST = 12'd2134;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ----- rtl/core/jadsc_divider.sv -----
// Restoring divider, one quotient bit per cycle, shared by the average and the position.
module jadsc_divider #(
    parameter int DVD_W = 19
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [DVD_W-1:0]              dividend,
    input  logic [jadsc_pkg::DATA_W-1:0]  divisor,
    output logic [DVD_W-1:0]              quotient,
    output jadsc_pkg::div_stat_t          stat
);

    localparam int CNT_W = $clog2(DVD_W + 1);
    localparam int DW = jadsc_pkg::DATA_W;

    logic [DVD_W-1:0] quo_reg;
    logic [DVD_W-1:0] quo_next;
    logic [DW-1:0]    rem_reg;
    logic [DW-1:0]    rem_next;
    logic [DW-1:0]    dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DW:0]      shifted;
    logic [DW:0]      trial;
    logic             fits;

    always_comb
    begin
        shifted = {rem_reg, quo_reg[DVD_W-1]};
        trial = shifted - {1'b0, dvs_reg};
        fits = !trial[DW];
        rem_next = fits ? trial[DW-1:0] : shifted[DW-1:0];
        quo_next = {quo_reg[DVD_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= CNT_W'(DVD_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign quotient = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider started while busy");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (!busy_reg && $past(busy_reg)))
        else $error("divider done without a finished run");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("divider done held for more than one cycle");

endmodule

// ----- rtl/core/joystick_axis_deadzone_scaler_core.sv -----
// Joystick axis dead-zone scaler: sample averaging and percent deflection for one axis.
//
//  channel | signals                                        | direction
//  --------+------------------------------------------------+----------
//  input   | in_valid, in_ready, raw_sample                 | in
//  result  | out_valid, out_ready, position, sample_average, | out
//          | changed                                        |
//  config  | cfg_valid, cfg_ready, cfg_index, cfg_data      | in
//
//  A sample that does not close a reading is taken whenever the core is idle.
//  A sample that closes a reading holds in_ready low through S_AVG, S_POS_SET,
//  S_POS (only when the position needs a division) and S_FINISH:
//  the shared restoring divider yields one quotient bit a cycle,
//  once for the average and once for the position.
//  A closing sample also waits while a previous result is still not transferred.
//  Reset clears the running sum, count, previous position and loads the default
//  dead-zone limits; cfg_ready is always high.
module joystick_axis_deadzone_scaler_core #(
    parameter int SAMPLES_PER_READING = 3
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [jadsc_pkg::DATA_W-1:0]         raw_sample,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [jadsc_pkg::POS_W-1:0]   position,
    output logic [jadsc_pkg::DATA_W-1:0]         sample_average,
    output logic                                 changed,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [jadsc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [jadsc_pkg::DATA_W-1:0]         cfg_data
);

    localparam int DW = jadsc_pkg::DATA_W;
    localparam int PW = jadsc_pkg::POS_W;
    localparam int SUM_W = $clog2(SAMPLES_PER_READING * 4095 + 1);
    localparam int CNT_W = $clog2(SAMPLES_PER_READING + 1);
    localparam int DVD_W = (SUM_W > jadsc_pkg::PROD_W) ? SUM_W : jadsc_pkg::PROD_W;
    localparam int PROD_W = jadsc_pkg::PROD_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_AVG,
        S_POS_SET,
        S_POS,
        S_FINISH
    } state_t;

    state_t                  state_reg;
    logic [SUM_W-1:0]        sum_reg;
    logic [CNT_W-1:0]        count_reg;
    logic [DW-1:0]           dead_low_reg;
    logic [DW-1:0]           dead_high_reg;
    logic [DW-1:0]           avg_reg;
    logic signed [PW-1:0]    pos_reg;
    logic signed [PW-1:0]    last_pos_reg;
    logic                    neg_reg;
    logic                    changed_reg;
    logic                    out_valid_reg;
    logic                    div_start_reg;
    logic [DVD_W-1:0]        dvd_reg;
    logic [DW-1:0]           dvs_reg;

    logic [DVD_W-1:0]        quotient;
    jadsc_pkg::div_stat_t    div_stat;

    logic                    last_sample;
    logic                    in_xfer;
    logic [DW-1:0]           inverted;
    logic [SUM_W-1:0]        sum_next;
    logic                    upper;
    logic                    lower;
    logic [DW-1:0]           span;
    logic [DW-1:0]           diff;
    logic [PROD_W-1:0]       prod;
    logic [DW-1:0]           dvs_sel;
    logic                    need_div;
    logic [PW-1:0]           quo_pos;

    always_comb
    begin
        last_sample = (count_reg == CNT_W'(SAMPLES_PER_READING - 1));
        in_ready = (state_reg == S_IDLE) && !(last_sample && out_valid_reg);
        in_xfer = in_valid && in_ready;
        inverted = jadsc_pkg::FULL_SCALE - raw_sample;
        sum_next = sum_reg + SUM_W'(inverted);

        upper = (avg_reg >= dead_high_reg);
        lower = (avg_reg <= dead_low_reg) && (dead_low_reg != '0);
        span = jadsc_pkg::FULL_SCALE - dead_high_reg;
        diff = upper ? (avg_reg - dead_high_reg) : (dead_low_reg - avg_reg);
        prod = (PROD_W'(diff) << 6) + (PROD_W'(diff) << 5) + (PROD_W'(diff) << 2);
        dvs_sel = upper ? span : dead_low_reg;
        need_div = upper ? (span != '0) : lower;
        quo_pos = quotient[PW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sum_reg <= '0;
            count_reg <= '0;
            dead_low_reg <= jadsc_pkg::DEAD_LOW_RST;
            dead_high_reg <= jadsc_pkg::DEAD_HIGH_RST;
            last_pos_reg <= '0;
            out_valid_reg <= 1'b0;
            div_start_reg <= 1'b0;
            avg_reg <= '0;
            pos_reg <= '0;
            neg_reg <= 1'b0;
            changed_reg <= 1'b0;
            dvd_reg <= '0;
            dvs_reg <= '0;
        end
        else
        begin
            div_start_reg <= 1'b0;

            if (cfg_valid)
            begin
                unique case (cfg_index)
                    jadsc_pkg::CFG_DEAD_LOW:  dead_low_reg <= cfg_data;
                    jadsc_pkg::CFG_DEAD_HIGH: dead_high_reg <= cfg_data;
                    default: ;
                endcase
            end

            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_xfer)
                    begin
                        if (last_sample)
                        begin
                            dvd_reg <= DVD_W'(sum_next);
                            dvs_reg <= DW'(SAMPLES_PER_READING);
                            div_start_reg <= 1'b1;
                            sum_reg <= '0;
                            count_reg <= '0;
                            state_reg <= S_AVG;
                        end
                        else
                        begin
                            sum_reg <= sum_next;
                            count_reg <= count_reg + CNT_W'(1);
                        end
                    end
                end
                S_AVG:
                begin
                    if (div_stat.done)
                    begin
                        avg_reg <= quotient[DW-1:0];
                        state_reg <= S_POS_SET;
                    end
                end
                S_POS_SET:
                begin
                    if (need_div)
                    begin
                        dvd_reg <= DVD_W'(prod);
                        dvs_reg <= dvs_sel;
                        div_start_reg <= 1'b1;
                        neg_reg <= !upper;
                        state_reg <= S_POS;
                    end
                    else
                    begin
                        pos_reg <= '0;
                        state_reg <= S_FINISH;
                    end
                end
                S_POS:
                begin
                    if (div_stat.done)
                    begin
                        pos_reg <= neg_reg ? (PW'(0) - quo_pos) : quo_pos;
                        state_reg <= S_FINISH;
                    end
                end
                S_FINISH:
                begin
                    changed_reg <= (pos_reg != last_pos_reg);
                    last_pos_reg <= pos_reg;
                    out_valid_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    jadsc_divider #(
        .DVD_W(DVD_W)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .dividend (dvd_reg),
        .divisor  (dvs_reg),
        .quotient (quotient),
        .stat     (div_stat)
    );

    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign position = pos_reg;
    assign sample_average = avg_reg;
    assign changed = changed_reg;

    a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_ready)
        else $error("input taken while a reading is in progress");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg < CNT_W'(SAMPLES_PER_READING))
        else $error("sample count past the reading length");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (pos_reg <= 8'sd100 && pos_reg >= -8'sd100))
        else $error("position outside percent range");

    a_changed_flag: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> (changed_reg == (pos_reg != $past(last_pos_reg))))
        else $error("changed flag disagrees with previous position");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH) |-> !out_valid_reg)
        else $error("result finished while previous result pending");

endmodule

// ----- test/joystick_axis_deadzone_scaler_core_tb.sv -----
// Self-checking testbench for the joystick axis dead-zone scaler: corners, then random readings.
module joystick_axis_deadzone_scaler_core_tb;

    localparam int DATA_W = jadsc_pkg::DATA_W;
    localparam int POS_W = jadsc_pkg::POS_W;
    localparam int CFG_IDX_W = jadsc_pkg::CFG_IDX_W;
    localparam logic [DATA_W-1:0] FULL_SCALE = jadsc_pkg::FULL_SCALE;
    localparam logic [DATA_W-1:0] DEAD_LOW_RST = jadsc_pkg::DEAD_LOW_RST;
    localparam logic [DATA_W-1:0] DEAD_HIGH_RST = jadsc_pkg::DEAD_HIGH_RST;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_LOW = jadsc_pkg::CFG_DEAD_LOW;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_HIGH = jadsc_pkg::CFG_DEAD_HIGH;

    localparam int SAMPLES = 3;
    localparam int SETTLE_CYCLES = 60;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int RANDOM_ITEMS = 2000;
    localparam int RANDOM_PHASES = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    typedef struct {
        logic signed [POS_W-1:0] pos;
        logic [DATA_W-1:0] avg;
        logic chg;
    } reading_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic [DATA_W-1:0] raw_sample;
    logic out_valid;
    logic out_ready;
    logic signed [POS_W-1:0] position;
    logic [DATA_W-1:0] sample_average;
    logic changed;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DATA_W-1:0] cfg_data;

    reading_t pending_readings[$];
    int mismatches = 0;
    int inv_sum = 0;
    int inv_count = 0;
    logic signed [POS_W-1:0] prev_position = '0;
    logic [DATA_W-1:0] lim_low = DEAD_LOW_RST;
    logic [DATA_W-1:0] lim_high = DEAD_HIGH_RST;
    bit tx_gaps = 0;
    bit rx_stalls = 0;
    bit long_hold = 0;

    joystick_axis_deadzone_scaler_core #(
        .SAMPLES_PER_READING(SAMPLES)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .raw_sample(raw_sample),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .position(position),
        .sample_average(sample_average),
        .changed(changed),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #1_000_000;
        $display("[joystick_axis_deadzone_scaler_core] ERROR");
        $finish;
    end

    function automatic logic signed [POS_W-1:0] deflection(input int avg);
        int lo;
        int hi;
        int mag;
        int span;
        logic signed [POS_W-1:0] p;
        lo = int'(lim_low);
        hi = int'(lim_high);
        p = '0;
        if (avg <= lo && lo != 0)
        begin
            mag = ((lo - avg) * 100) / lo;
            p = POS_W'(-mag);
        end
        if (avg >= hi)
        begin
            span = int'(FULL_SCALE) - hi;
            p = '0;
            if (span != 0)
                p = POS_W'(((avg - hi) * 100) / span);
        end
        return p;
    endfunction

    task automatic predict_reading(input logic [DATA_W-1:0] raw);
        reading_t r;
        int avg;
        inv_sum += int'(FULL_SCALE) - int'(raw);
        inv_count++;
        if (inv_count == SAMPLES)
        begin
            avg = inv_sum / SAMPLES;
            r.avg = DATA_W'(avg);
            r.pos = deflection(avg);
            r.chg = (r.pos != prev_position);
            prev_position = r.pos;
            inv_sum = 0;
            inv_count = 0;
            pending_readings.push_back(r);
        end
    endtask

    function automatic int tx_gap();
        int r;
        if (!tx_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 4);
        return $urandom_range(20, 80);
    endfunction

    function automatic int rx_stall();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85)
            return $urandom_range(1, 3);
        return $urandom_range(10, 50);
    endfunction

    task automatic send_sample(input logic [DATA_W-1:0] raw);
        int gap;
        gap = tx_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        raw_sample <= raw;
        do @(posedge clk); while (!in_ready);
        predict_reading(raw);
    endtask

    task automatic send_inverted(input int inv);
        if (inv < 0)
            inv = 0;
        if (inv > int'(FULL_SCALE))
            inv = int'(FULL_SCALE);
        send_sample(FULL_SCALE - DATA_W'(inv));
    endtask

    task automatic stop_samples();
        in_valid <= 1'b0;
    endtask

    task automatic wait_drain();
        while (pending_readings.size() != 0)
            @(posedge clk);
    endtask

    task automatic quiesce();
        stop_samples();
        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_xfer(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        if (idx == CFG_DEAD_LOW)
            lim_low = val;
        else if (idx == CFG_DEAD_HIGH)
            lim_high = val;
    endtask

    task automatic set_limits(input logic [DATA_W-1:0] lo, input logic [DATA_W-1:0] hi);
        cfg_xfer(CFG_DEAD_LOW, lo);
        cfg_xfer(CFG_DEAD_HIGH, hi);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_reading(input int target);
        repeat (SAMPLES) send_inverted(target + $urandom_range(0, 4) - 2);
    endtask

    task automatic test_reset_limits();
        repeat (SAMPLES) send_sample(FULL_SCALE);
        repeat (SAMPLES) send_sample('0);
        repeat (SAMPLES) send_inverted(2129);
        send_sample(12'hAAA);
        send_sample(12'h555);
        send_sample(12'hF0F);
        quiesce();
    endtask

    task automatic test_degenerate_limits();
        set_limits('0, FULL_SCALE);
        repeat (SAMPLES) send_inverted(0);
        repeat (SAMPLES) send_inverted(int'(FULL_SCALE));
        quiesce();
    endtask

    task automatic test_overlapping_limits();
        set_limits(12'd3000, 12'd1000);
        repeat (SAMPLES) send_inverted(2000);
        quiesce();
    endtask

    task automatic test_write_mid_reading();
        send_inverted(100);
        quiesce();
        set_limits(12'd500, 12'd600);
        cfg_xfer(CFG_SPARE_A, 12'hFFF);
        cfg_xfer(CFG_SPARE_B, 12'h000);
        cfg_valid <= 1'b0;
        repeat (SAMPLES - 1) send_inverted(100);
        quiesce();
    endtask

    task automatic test_backpressure();
        tx_gaps = 0;
        long_hold = 1;
        repeat (5) send_reading($urandom_range(0, 4095));
        stop_samples();
        wait_drain();
        repeat (3) send_reading($urandom_range(0, 4095));
        quiesce();
    endtask

    task automatic test_random_readings();
        int per_phase;
        int sent;
        int kind;
        int target;
        per_phase = RANDOM_ITEMS / RANDOM_PHASES;
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph)
                0: set_limits(12'd1, 12'd4094);
                1: set_limits(FULL_SCALE, '0);
                2: set_limits('0, FULL_SCALE);
                default: set_limits(DATA_W'($urandom_range(0, 4095)),
                                    DATA_W'($urandom_range(0, 4095)));
            endcase
            if (ph % 2 == 1)
            begin
                cfg_xfer(CFG_SPARE_A, DATA_W'($urandom_range(0, 4095)));
                cfg_valid <= 1'b0;
            end
            tx_gaps = (ph % 3 != 0);
            rx_stalls = (ph % 4 != 1);
            if (ph == 4)
                long_hold = 1;
            sent = 0;
            while (sent < per_phase)
            begin
                kind = $urandom_range(0, 9);
                if (kind < 2)
                begin
                    repeat (SAMPLES) send_sample(DATA_W'($urandom_range(0, 4095)));
                end
                else if (kind == 2)
                begin
                    repeat (SAMPLES) send_sample($urandom_range(0, 1) ? FULL_SCALE : '0);
                end
                else
                begin
                    case ($urandom_range(0, 4))
                        0: target = int'(lim_low) + $urandom_range(0, 6) - 3;
                        1: target = int'(lim_high) + $urandom_range(0, 6) - 3;
                        2: target = 0;
                        3: target = int'(FULL_SCALE);
                        default: target = $urandom_range(0, 4095);
                    endcase
                    send_reading(target);
                end
                sent += SAMPLES;
                if ($urandom_range(0, 39) == 0)
                begin
                    stop_samples();
                    wait_drain();
                end
            end
            quiesce();
        end
    endtask

    initial
    begin
        out_ready <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever
        begin
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clk);
            if (long_hold)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                long_hold = 0;
            end
            else if (rx_stalls)
            begin
                out_ready <= 1'b0;
                repeat (rx_stall()) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        reading_t exp_r;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_readings.size() == 0)
            begin
                $error("unexpected transfer: position %0d sample_average %0d changed %0b",
                       position, sample_average, changed);
                mismatches++;
            end
            else
            begin
                exp_r = pending_readings.pop_front();
                if (position !== exp_r.pos)
                begin
                    $error("position: expected %0d, actual %0d", exp_r.pos, position);
                    mismatches++;
                end
                if (sample_average !== exp_r.avg)
                begin
                    $error("sample_average: expected %0d, actual %0d", exp_r.avg,
                           sample_average);
                    mismatches++;
                end
                if (changed !== exp_r.chg)
                begin
                    $error("changed: expected %0b, actual %0b", exp_r.chg, changed);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        raw_sample <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_limits();
        test_degenerate_limits();
        test_overlapping_limits();
        test_write_mid_reading();
        rx_stalls = 1;
        test_backpressure();
        test_random_readings();

        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_readings.size() != 0)
        begin
            $error("%0d readings never transferred", pending_readings.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("[joystick_axis_deadzone_scaler_core] OK");
        else
            $display("[joystick_axis_deadzone_scaler_core] ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/jadsc_pkg.sv
rtl/core/jadsc_divider.sv
rtl/core/joystick_axis_deadzone_scaler_core.sv
test/joystick_axis_deadzone_scaler_core_tb.sv
